// File: rtl/core/lpd_pkg.sv
// Shared types and constants for the light level phase delay loop.
// No dependencies; imported by lpd_div and light_level_phase_delay_loop.
package lpd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 14;
  localparam int HOLD_W     = 4;
  localparam int PCT_W      = 7;
  localparam int RANGE_W    = 16;
  localparam int TOL_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DIVIDEND_W = 33;
  localparam int DIVISOR_W  = 19;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUX_SPAN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 2'd2;

  localparam logic [PCT_W-1:0]   PCT_RESET   = 7'd50;
  localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 16'd150;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 10'd10;

  localparam logic [DELAY_W-1:0] DELAY_FLOOR = 14'd100;
  localparam logic [DELAY_W-1:0] DELAY_LIMIT = 14'd8500;
  localparam logic [DELAY_W-1:0] DELAY_CEIL  = 14'd8300;
  localparam logic [DELAY_W-1:0] FINE_STEP   = 14'd10;
  localparam logic [HOLD_W-1:0]  WAIT_FAST   = 4'd3;
  localparam logic [HOLD_W-1:0]  WAIT_SLOW   = 4'd15;

  localparam int GAIN_NUM  = 33332;
  // floor(2^22 / 100), one correction step recovers x / 100 for x < 2^23
  localparam int RECIP_100 = 41943;
  localparam int RECIP_SH  = 22;

  typedef struct packed {
    logic [SAMPLE_W-1:0] light_sample;
    logic                power_on;
  } lpd_in_t;

  typedef struct packed {
    logic [DELAY_W-1:0] phase_delay_us;
    logic [HOLD_W-1:0]  hold_seconds;
    logic               delay_changed;
  } lpd_out_t;

endpackage

// File: rtl/core/lpd_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on lpd_pkg for operand widths.
module lpd_div
  import lpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    shifted  = {rem_r, quo_r[DIVIDEND_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVIDEND_W);
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!trial[DIVISOR_W+1]) begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

  a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r)
    else $error("divider finished without done");

endmodule

// File: rtl/core/light_level_phase_delay_loop.sv
// Light level phase delay loop, top level.
// Depends on lpd_pkg and lpd_div.
//
// Input channel in_valid/in_stall/in_data carries one light sample and the
// power flag; each transfer yields exactly one result on out_valid/out_stall/
// out_data: the new firing delay, the hold time and a reload flag.
// Registers target_percent (0), lux span (1) and tolerance (2) are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Items are processed one at a time; in_stall is high from the cycle after a
// transfer until the result is loaded into the output register.
// With power off an item goes from the transfer straight to S_DONE; a small or
// moderate error passes S_TGT_MUL, S_TGT_REC, S_TGT_BACK, S_TGT_FIX and S_ERR,
// and a large error adds S_P_MUL1, S_P_MUL2, S_P_SUB and S_DIV before S_DONE.
// The large-error path is set by the serial divide by 5x the span; the target
// and the products share one 24x18 multiplier over several steps.
// A new item may be taken while an earlier result still sits in the output
// register; if out_stall holds that result, the finished item waits in its
// last step until the output register frees.
// Synchronous reset restores the register defaults, the delay to
// PHASE_DELAY_RESET and the hold time to 3, and empties the output register.
module light_level_phase_delay_loop
  import lpd_pkg::*;
#(
  parameter int PHASE_DELAY_RESET = 4000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lpd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lpd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TGT_MUL,
    S_TGT_REC,
    S_TGT_BACK,
    S_TGT_FIX,
    S_ERR,
    S_P_MUL1,
    S_P_MUL2,
    S_P_SUB,
    S_DIV,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [PCT_W-1:0]     pct_r, pct_nxt;
  logic [RANGE_W-1:0]   range_r, range_nxt;
  logic [TOL_W-1:0]     tol_r, tol_nxt;
  logic [DELAY_W-1:0]   delay_r, delay_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lpd_out_t             out_data_r, out_data_nxt;

  logic [SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic signed [41:0]   prod_r, prod_nxt;
  logic [22:0]          x_r, x_nxt;
  logic [15:0]          q0_r, q0_nxt;
  logic [15:0]          tgt_r, tgt_nxt;
  logic signed [16:0]   err_r, err_nxt;
  logic signed [33:0]   num_r, num_nxt;
  logic                 neg_r, neg_nxt;
  logic [DELAY_W-1:0]   nd_r, nd_nxt;
  logic [HOLD_W-1:0]    nh_r, nh_nxt;
  logic                 chg_r, chg_nxt;

  logic [PCT_W-1:0]     pct_eff;
  logic [RANGE_W-1:0]   range_eff;
  logic [DIVISOR_W-1:0] den;
  logic signed [23:0]   mul_a;
  logic signed [17:0]   mul_b;
  logic signed [41:0]   mul_p;
  logic [22:0]          fix_rem;
  logic signed [16:0]   err_c;
  logic [16:0]          mag_c;
  logic signed [15:0]   fine_nd;
  logic signed [33:0]   diff;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic                 div_start;
  logic                 div_done;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                 in_xfer;

  assign pct_eff   = (pct_r > PCT_FULL) ? PCT_FULL : pct_r;
  assign range_eff = (range_r == '0) ? RANGE_W'(1) : range_r;
  assign den       = {1'b0, range_eff, 2'b00} + {3'b000, range_eff};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TGT_MUL: begin
        mul_a = {8'd0, range_eff};
        mul_b = {11'd0, pct_eff};
      end
      S_TGT_REC: begin
        mul_a = {1'b0, prod_r[22:0]};
        mul_b = 18'(RECIP_100);
      end
      S_TGT_BACK: begin
        mul_a = {8'd0, prod_r[RECIP_SH+15:RECIP_SH]};
        mul_b = {11'd0, PCT_FULL};
      end
      S_P_MUL1: begin
        mul_a = {5'd0, den};
        mul_b = {4'd0, delay_r};
      end
      S_P_MUL2: begin
        mul_a = 24'(GAIN_NUM);
        mul_b = {err_r[16], err_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign fix_rem      = x_r - prod_r[22:0];
  assign err_c        = $signed({1'b0, tgt_r}) - $signed({1'b0, sample_r});
  assign mag_c        = err_c[16] ? 17'(-err_c) : 17'(err_c);
  assign fine_nd      = err_c[16] ? ($signed({2'b00, delay_r}) + $signed({2'b00, FINE_STEP}))
                                  : ($signed({2'b00, delay_r}) - $signed({2'b00, FINE_STEP}));
  assign diff         = num_r - prod_r[33:0];
  assign div_dividend = diff[33] ? DIVIDEND_W'(-diff) : diff[DIVIDEND_W-1:0];
  assign div_start    = (state_r == S_P_SUB);
  assign in_xfer      = in_valid && !in_stall;

  lpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    pct_nxt       = pct_r;
    range_nxt     = range_r;
    tol_nxt       = tol_r;
    delay_nxt     = delay_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    sample_nxt    = sample_r;
    prod_nxt      = prod_r;
    x_nxt         = x_r;
    q0_nxt        = q0_r;
    tgt_nxt       = tgt_r;
    err_nxt       = err_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    nd_nxt        = nd_r;
    nh_nxt        = nh_r;
    chg_nxt       = chg_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_PERCENT: pct_nxt   = cfg_data[PCT_W-1:0];
        CFG_LUX_SPAN:       range_nxt = cfg_data[RANGE_W-1:0];
        CFG_TOLERANCE:      tol_nxt   = cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          sample_nxt = in_data.light_sample;
          if (!in_data.power_on) begin
            nd_nxt    = delay_r;
            nh_nxt    = WAIT_FAST;
            chg_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_TGT_MUL;
          end
        end
      end
      S_TGT_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_TGT_REC;
      end
      S_TGT_REC: begin
        x_nxt     = prod_r[22:0];
        prod_nxt  = mul_p;
        state_nxt = S_TGT_BACK;
      end
      S_TGT_BACK: begin
        q0_nxt    = prod_r[RECIP_SH+15:RECIP_SH];
        prod_nxt  = mul_p;
        state_nxt = S_TGT_FIX;
      end
      S_TGT_FIX: begin
        tgt_nxt   = q0_r + 16'(fix_rem >= 23'(PCT_FULL));
        state_nxt = S_ERR;
      end
      S_ERR: begin
        err_nxt = err_c;
        if (mag_c <= {7'd0, tol_r}) begin
          nd_nxt    = delay_r;
          nh_nxt    = hold_r;
          chg_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (mag_c > {6'd0, tol_r, 1'b0}) begin
          state_nxt = S_P_MUL1;
        end else begin
          if (fine_nd[15]) begin
            nd_nxt = DELAY_FLOOR;
          end else if (fine_nd[14:0] > {1'b0, DELAY_LIMIT}) begin
            nd_nxt = DELAY_CEIL;
          end else begin
            nd_nxt = fine_nd[DELAY_W-1:0];
          end
          nh_nxt    = WAIT_SLOW;
          chg_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_P_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = S_P_MUL2;
      end
      S_P_MUL2: begin
        num_nxt   = prod_r[33:0];
        prod_nxt  = mul_p;
        state_nxt = S_P_SUB;
      end
      S_P_SUB: begin
        neg_nxt   = diff[33];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (neg_r && (div_quo != '0)) begin
            nd_nxt = DELAY_FLOOR;
          end else if (div_quo > DIVIDEND_W'(DELAY_LIMIT)) begin
            nd_nxt = DELAY_CEIL;
          end else begin
            nd_nxt = div_quo[DELAY_W-1:0];
          end
          nh_nxt    = WAIT_FAST;
          chg_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.phase_delay_us = nd_r;
          out_data_nxt.hold_seconds   = nh_r;
          out_data_nxt.delay_changed  = chg_r;
          delay_nxt                   = nd_r;
          hold_nxt                    = nh_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pct_r       <= PCT_RESET;
      range_r     <= RANGE_RESET;
      tol_r       <= TOL_RESET;
      delay_r     <= DELAY_W'(PHASE_DELAY_RESET);
      hold_r      <= WAIT_FAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pct_r       <= pct_nxt;
      range_r     <= range_nxt;
      tol_r       <= tol_nxt;
      delay_r     <= delay_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    sample_r   <= sample_nxt;
    prod_r     <= prod_nxt;
    x_r        <= x_nxt;
    q0_r       <= q0_nxt;
    tgt_r      <= tgt_nxt;
    err_r      <= err_nxt;
    num_r      <= num_nxt;
    neg_r      <= neg_nxt;
    nd_r       <= nd_nxt;
    nh_r       <= nh_nxt;
    chg_r      <= chg_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input taken again before item finished");

  a_delay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    delay_r <= DELAY_LIMIT)
    else $error("phase delay above limit");

  a_hold_codes: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r == WAIT_FAST || hold_r == WAIT_SLOW)
    else $error("hold time not 3 or 15");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide step");

endmodule
